FILE: design/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, widths, register codes and latencies of the barometric
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int RAW_W      = 20;
    localparam int FINE_W     = 20;
    localparam int CENT_W     = 16;
    localparam int PRES_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // stage counts of each pipeline section
    localparam int MUL_LAT    = 2;
    localparam int TEMP_LAT   = 5;
    localparam int PFRONT_LAT = 10;
    localparam int DIV_STEPS  = 64;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int PBACK_LAT  = 6;
    localparam int TOTAL_LAT  = TEMP_LAT + PFRONT_LAT + DIV_LAT + PBACK_LAT;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CAL   = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
    } temp_cal_t;

    typedef struct packed {
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } press_cal_t;

    // sign-extend a 16-bit calibration word to 64 bits
    function automatic logic [63:0] sx16(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    // arithmetic right shift of a 64-bit two's complement word
    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
        return $unsigned($signed(x) >>> n);
    endfunction

endpackage

FILE: design/bmp_delay.sv
// ----------------------------------------------------------------------------
// bmp_delay
// Stallable shift line that keeps side data aligned with a pipeline section.
// ----------------------------------------------------------------------------
module bmp_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    // first tap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
        end
    end

    // remaining taps
    for (genvar i = 1; i < N; i++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

FILE: design/bmp_mul64.sv
// ----------------------------------------------------------------------------
// bmp_mul64
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product from
// three 32 x 32 partial products.
// ----------------------------------------------------------------------------
module bmp_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] y,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;
    logic [63:0] lh_full;
    logic [63:0] hl_full;

    assign lh_full = x[31:0] * y[63:32];
    assign hl_full = x[63:32] * y[31:0];

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= x[31:0] * y[31:0];
            lh_reg <= lh_full[31:0];
            hl_reg <= hl_full[31:0];
        end
    end

    // combine, cross terms only reach the upper half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

FILE: design/bmp_temp.sv
// ----------------------------------------------------------------------------
// bmp_temp
// Five-stage temperature section: fine temperature and centidegrees,
// both saturated.
// ----------------------------------------------------------------------------
module bmp_temp #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              en,
    input  bmp_pkg::temp_cal_t                cal,
    input  logic        [bmp_pkg::RAW_W-1:0]  raw_t,
    input  logic        [SIDE_W-1:0]          side_in,
    output logic signed [bmp_pkg::FINE_W-1:0] fine,
    output logic signed [bmp_pkg::CENT_W-1:0] cent,
    output logic        [SIDE_W-1:0]          side_out
);

    import bmp_pkg::*;

    logic signed [17:0] x_reg;
    logic signed [16:0] d_reg;
    logic signed [33:0] m1_reg;
    logic        [32:0] dd_reg;
    logic signed [22:0] a_reg;
    logic signed [37:0] bb_reg;
    logic signed [23:0] tf_reg;
    logic signed [FINE_W-1:0] fine_reg;
    logic signed [CENT_W-1:0] cent_reg;

    logic signed [17:0] x_next;
    logic signed [16:0] d_next;
    logic signed [33:0] m1_next;
    logic signed [33:0] dsq;
    logic signed [37:0] bb_next;
    logic signed [23:0] tf_next;
    logic signed [26:0] c5;
    logic signed [26:0] cs;

    // differences against t1
    assign x_next = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    assign d_next = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cal.t1});

    // products
    assign m1_next = 34'(x_reg) * 34'(cal.t2);
    assign dsq     = 34'(d_reg) * 34'(d_reg);
    assign bb_next = 38'($signed({1'b0, dd_reg[32:12]})) * 38'(cal.t3);
    assign tf_next = 24'(a_reg) + 24'(bb_reg >>> 14);

    // centidegree rounding
    assign c5 = 27'(tf_reg) * 27'sd5 + 27'sd128;
    assign cs = c5 >>> 8;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            d_reg  <= d_next;
            m1_reg <= m1_next;
            dd_reg <= dsq[32:0];
            a_reg  <= 23'(m1_reg >>> 11);
            bb_reg <= bb_next;
            tf_reg <= tf_next;
        end
    end

    // saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (tf_reg > 24'sd524287)
            begin
                fine_reg <= 20'sh7FFFF;
            end
            else if (tf_reg < -24'sd524288)
            begin
                fine_reg <= 20'sh80000;
            end
            else
            begin
                fine_reg <= tf_reg[FINE_W-1:0];
            end
            if (cs > 27'sd32767)
            begin
                cent_reg <= 16'sh7FFF;
            end
            else if (cs < -27'sd32768)
            begin
                cent_reg <= 16'sh8000;
            end
            else
            begin
                cent_reg <= cs[CENT_W-1:0];
            end
        end
    end

    assign fine = fine_reg;
    assign cent = cent_reg;

    bmp_delay #(.W(SIDE_W), .N(TEMP_LAT)) u_side (
        .clk (clk),
        .en  (en),
        .d   (side_in),
        .q   (side_out)
    );

endmodule

FILE: design/bmp_pfront.sv
// ----------------------------------------------------------------------------
// bmp_pfront
// Pressure front section: builds the 64-bit dividend and the divisor from
// the fine temperature, the raw pressure and the calibration words.
// ----------------------------------------------------------------------------
module bmp_pfront #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              en,
    input  bmp_pkg::press_cal_t               cal,
    input  logic signed [bmp_pkg::FINE_W-1:0] fine,
    input  logic        [bmp_pkg::RAW_W-1:0]  raw_p,
    input  logic        [SIDE_W-1:0]          side_in,
    output logic        [63:0]                num,
    output logic        [30:0]                den,
    output logic                              fault,
    output logic        [SIDE_W-1:0]          side_out
);

    import bmp_pkg::*;

    logic [63:0] av_reg;
    logic [63:0] pp_reg;
    logic [63:0] aa;
    logic [63:0] ap5;
    logic [63:0] ap2;
    logic [63:0] ap5_d;
    logic [63:0] ap2_d;
    logic [63:0] pp_d;
    logic [63:0] b1;
    logic [63:0] a1;
    logic [63:0] b_reg;
    logic [63:0] a2_reg;
    logic [63:0] c_reg;
    logic [63:0] nb_reg;
    logic [63:0] cp;
    logic [63:0] n3125;
    logic [63:0] num_reg;
    logic [30:0] den_reg;
    logic        fault_reg;

    // offset fine temperature and inverted pressure count
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            av_reg <= {{(64-FINE_W){fine[FINE_W-1]}}, fine} - 64'd128000;
            pp_reg <= 64'd1048576 - {{(64-RAW_W){1'b0}}, raw_p};
        end
    end

    // first products
    bmp_mul64 u_aa  (.clk(clk), .en(en), .x(av_reg), .y(av_reg),      .p(aa));
    bmp_mul64 u_ap5 (.clk(clk), .en(en), .x(av_reg), .y(sx16(cal.p5)), .p(ap5));
    bmp_mul64 u_ap2 (.clk(clk), .en(en), .x(av_reg), .y(sx16(cal.p2)), .p(ap2));

    // second products
    bmp_mul64 u_b1 (.clk(clk), .en(en), .x(aa), .y(sx16(cal.p6)), .p(b1));
    bmp_mul64 u_a1 (.clk(clk), .en(en), .x(aa), .y(sx16(cal.p3)), .p(a1));

    bmp_delay #(.W(128), .N(MUL_LAT)) u_apd (
        .clk (clk),
        .en  (en),
        .d   ({ap5, ap2}),
        .q   ({ap5_d, ap2_d})
    );

    bmp_delay #(.W(64), .N(2 * MUL_LAT + 1)) u_ppd (
        .clk (clk),
        .en  (en),
        .d   (pp_reg),
        .q   (pp_d)
    );

    // sum terms, then dividend and divisor operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg  <= b1 + (ap5_d << 17) + (sx16(cal.p4) << 35);
            a2_reg <= asr64(a1, 8) + (ap2_d << 12);
            c_reg  <= 64'h0000_8000_0000_0000 + a2_reg;
            nb_reg <= (pp_d << 31) - b_reg;
        end
    end

    // third products
    bmp_mul64 u_cp (.clk(clk), .en(en), .x(c_reg),  .y({48'd0, cal.p1}), .p(cp));
    bmp_mul64 u_n  (.clk(clk), .en(en), .x(nb_reg), .y(64'd3125),        .p(n3125));

    // divisor is the product shifted down by 33
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= n3125;
            den_reg   <= cp[63:33];
            fault_reg <= (cp[63:33] == 31'd0);
        end
    end

    assign num   = num_reg;
    assign den   = den_reg;
    assign fault = fault_reg;

    bmp_delay #(.W(SIDE_W), .N(PFRONT_LAT)) u_side (
        .clk (clk),
        .en  (en),
        .d   (side_in),
        .q   (side_out)
    );

endmodule

FILE: design/bmp_div.sv
// ----------------------------------------------------------------------------
// bmp_div
// Pipelined signed divider, 64-bit dividend by 31-bit divisor, one
// quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module bmp_div #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [63:0]       num,
    input  logic [30:0]       den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [63:0]       quot,
    output logic [SIDE_W-1:0] side_out
);

    import bmp_pkg::*;

    logic [30:0] rem_reg [0:DIV_STEPS];
    logic [63:0] nq_reg  [0:DIV_STEPS];
    logic [30:0] den_reg [0:DIV_STEPS];
    logic        neg_reg [0:DIV_STEPS];
    logic [63:0] quot_reg;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 31'd0;
            nq_reg[0]  <= num[63] ? (64'd0 - num) : num;
            den_reg[0] <= den[30] ? (31'd0 - den) : den;
            neg_reg[0] <= num[63] ^ den[30];
        end
    end

    // restoring steps
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [31:0] r_sh;
        logic [31:0] diff;
        logic        take;

        assign r_sh = {rem_reg[i], nq_reg[i][63]};
        assign diff = r_sh - {1'b0, den_reg[i]};
        assign take = (r_sh >= {1'b0, den_reg[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= take ? diff[30:0] : r_sh[30:0];
                nq_reg[i+1]  <= {nq_reg[i][62:0], take};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // apply sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= neg_reg[DIV_STEPS] ? (64'd0 - nq_reg[DIV_STEPS])
                                           : nq_reg[DIV_STEPS];
        end
    end

    assign quot = quot_reg;

    bmp_delay #(.W(SIDE_W), .N(DIV_LAT)) u_side (
        .clk (clk),
        .en  (en),
        .d   (side_in),
        .q   (side_out)
    );

endmodule

FILE: design/bmp_pback.sv
// ----------------------------------------------------------------------------
// bmp_pback
// Pressure back section: quadratic correction of the quotient and the
// final offset, giving pressure in Q24.8.
// ----------------------------------------------------------------------------
module bmp_pback #(
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             en,
    input  bmp_pkg::press_cal_t              cal,
    input  logic [63:0]                      quot,
    input  logic [SIDE_W-1:0]                side_in,
    output logic [bmp_pkg::PRES_W-1:0]       pres,
    output logic [SIDE_W-1:0]                side_out
);

    import bmp_pkg::*;

    logic [63:0] ps;
    logic [63:0] s2;
    logic [63:0] s3;
    logic [63:0] v2m;
    logic [63:0] v2m_d;
    logic [63:0] q_d;
    logic [63:0] sum_reg;
    logic [63:0] fin;
    logic [PRES_W-1:0] pres_reg;

    assign ps = asr64(quot, 13);

    // square of the scaled quotient and the linear term
    bmp_mul64 u_s2 (.clk(clk), .en(en), .x(ps),   .y(ps),            .p(s2));
    bmp_mul64 u_v2 (.clk(clk), .en(en), .x(quot), .y(sx16(cal.p8)), .p(v2m));

    // quadratic term
    bmp_mul64 u_s3 (.clk(clk), .en(en), .x(s2), .y(sx16(cal.p9)), .p(s3));

    bmp_delay #(.W(64), .N(MUL_LAT)) u_v2d (
        .clk (clk),
        .en  (en),
        .d   (v2m),
        .q   (v2m_d)
    );

    bmp_delay #(.W(64), .N(2 * MUL_LAT)) u_qd (
        .clk (clk),
        .en  (en),
        .d   (quot),
        .q   (q_d)
    );

    assign fin = asr64(sum_reg, 8) + (sx16(cal.p7) << 4);

    // sum of terms, then offset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= q_d + asr64(s3, 25) + asr64(v2m_d, 19);
            pres_reg <= fin[PRES_W-1:0];
        end
    end

    assign pres = pres_reg;

    bmp_delay #(.W(SIDE_W), .N(PBACK_LAT)) u_side (
        .clk (clk),
        .en  (en),
        .d   (side_in),
        .q   (side_out)
    );

endmodule

FILE: design/barometric_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_top
// Temperature and pressure compensation of raw barometric sensor readings.
// ----------------------------------------------------------------------------
// Usage:
// - s_* stream: one beat holds a raw temperature and a raw pressure reading.
// - m_* stream: one beat per input beat, in order, with the fine temperature,
//   the temperature in centidegrees, pressure in Q24.8 and, on m_tuser, a
//   flag set when the pressure divisor was zero (pressure then reads 0).
// - cfg_* port: writes one of four calibration registers; always ready.
//   Write it only while no beat is in flight.
// - The pipeline has 5 temperature stages, 10 pressure front stages,
//   66 divider stages (one quotient bit per restoring step) and 6 back stages.
// - One beat per cycle unless stalled; every stage holds its own item.
// - The whole pipeline advances together whenever the output register is
//   empty or taken; while m_tready is low with a result waiting, the
//   pipeline holds and s_tready is low. Bubbles hold their place as well,
//   they are not squeezed out during a stall.
// - Reset clears the calibration registers to zero and empties the pipe.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  logic [39:0]                        s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fine_temperature [19:0], temperature_centideg [35:20],
    // pressure_q24_8 [67:36], zero pad [71:68]
    output logic [71:0]                        m_tdata,
    // divide_fault [0]
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bmp_pkg::*;

    localparam int SIDE1_W = FINE_W + CENT_W;
    localparam int SIDE2_W = SIDE1_W + 1;

    temp_cal_t  temp_cal_reg;
    press_cal_t press_cal_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic en;

    logic signed [FINE_W-1:0] fine_t;
    logic signed [CENT_W-1:0] cent_t;
    logic [RAW_W-1:0]         raw_p_t;
    logic [SIDE1_W-1:0]       side_f;
    logic [63:0]              num;
    logic [30:0]              den;
    logic                     fault_f;
    logic [63:0]              quot;
    logic [SIDE2_W-1:0]       side_d;
    logic [PRES_W-1:0]        pres;
    logic [SIDE2_W-1:0]       side_b;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg  <= '0;
            press_cal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TEMP_CAL:
                begin
                    temp_cal_reg.t1 <= cfg_data[15:0];
                    temp_cal_reg.t2 <= cfg_data[31:16];
                    temp_cal_reg.t3 <= cfg_data[47:32];
                end
                CFG_PRESS_LOW:
                begin
                    press_cal_reg.p1 <= cfg_data[15:0];
                    press_cal_reg.p2 <= cfg_data[31:16];
                    press_cal_reg.p3 <= cfg_data[47:32];
                    press_cal_reg.p4 <= cfg_data[63:48];
                end
                CFG_PRESS_HIGH:
                begin
                    press_cal_reg.p5 <= cfg_data[15:0];
                    press_cal_reg.p6 <= cfg_data[31:16];
                    press_cal_reg.p7 <= cfg_data[47:32];
                    press_cal_reg.p8 <= cfg_data[63:48];
                end
                CFG_PRESS_LAST:
                begin
                    press_cal_reg.p9 <= cfg_data[15:0];
                end
                default:
                begin
                    press_cal_reg.p9 <= press_cal_reg.p9;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // global advance: output register free or being taken
    assign en       = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    bmp_temp #(.SIDE_W(RAW_W)) u_temp (
        .clk      (clk),
        .en       (en),
        .cal      (temp_cal_reg),
        .raw_t    (s_tdata[19:0]),
        .side_in  (s_tdata[39:20]),
        .fine     (fine_t),
        .cent     (cent_t),
        .side_out (raw_p_t)
    );

    bmp_pfront #(.SIDE_W(SIDE1_W)) u_pfront (
        .clk      (clk),
        .en       (en),
        .cal      (press_cal_reg),
        .fine     (fine_t),
        .raw_p    (raw_p_t),
        .side_in  ({cent_t, fine_t}),
        .num      (num),
        .den      (den),
        .fault    (fault_f),
        .side_out (side_f)
    );

    bmp_div #(.SIDE_W(SIDE2_W)) u_div (
        .clk      (clk),
        .en       (en),
        .num      (num),
        .den      (den),
        .side_in  ({fault_f, side_f}),
        .quot     (quot),
        .side_out (side_d)
    );

    bmp_pback #(.SIDE_W(SIDE2_W)) u_pback (
        .clk      (clk),
        .en       (en),
        .cal      (press_cal_reg),
        .quot     (quot),
        .side_in  (side_d),
        .pres     (pres),
        .side_out (side_b)
    );

    // output beat
    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_tuser  = side_b[SIDE2_W-1];
    assign m_tdata  = {4'd0, (side_b[SIDE2_W-1] ? {PRES_W{1'b0}} : pres),
                       side_b[SIDE1_W-1:0]};

endmodule
